FILE: rtl/psu_pkg.sv
// Shared types, constants and helpers for the particle swarm update block.
`timescale 1ns / 1ps
package psu_pkg;

  localparam int MaxParticles = 64;
  localparam int MaxDims = 16;
  localparam int StateWidth = 16;
  localparam int PartW = 6;
  localparam int DimW = 4;
  localparam int AddrW = PartW + DimW;
  localparam int DcntW = 5;
  localparam int ScoreW = 32;
  localparam logic [12:0] RandMax = 13'd4096;
  localparam logic signed [ScoreW-1:0] ScoreFloor = {1'b1, {(ScoreW-1){1'b0}}};

  // Input modes
  localparam logic [1:0] ModeLoad = 2'd0;
  localparam logic [1:0] ModeFit = 2'd1;
  localparam logic [1:0] ModeUpd = 2'd2;

  // Configuration register indexes
  localparam logic [1:0] RegInertia = 2'd0;
  localparam logic [1:0] RegCognitive = 2'd1;
  localparam logic [1:0] RegSocial = 2'd2;
  localparam logic [1:0] RegDims = 2'd3;

  // Classified command handed from front to back
  typedef struct packed {
    logic [1:0] mode;
    logic [PartW-1:0] particle;
    logic [DimW-1:0] dim_index;
    logic signed [StateWidth-1:0] load_position;
    logic signed [StateWidth-1:0] load_velocity;
    logic signed [ScoreW-1:0] fitness;
    logic [12:0] rand_one;
    logic [12:0] rand_two;
  } cmd_t;

  // Result item
  typedef struct packed {
    logic [DimW-1:0] out_dim;
    logic signed [StateWidth-1:0] out_position;
    logic signed [StateWidth-1:0] out_velocity;
    logic personal_improved;
    logic global_improved;
    logic last;
  } res_t;

  function automatic logic signed [StateWidth-1:0] sat_state(input logic signed [47:0] s);
    logic signed [47:0] hi;
    logic signed [47:0] lo;
    hi = 48'sd32767;
    lo = -48'sd32768;
    if (s > hi) return 16'sh7fff;
    else if (s < lo) return 16'sh8000;
    else return s[StateWidth-1:0];
  endfunction

endpackage

FILE: rtl/psu_front.sv
// Front end: accepts input items, drops ignored ones, queues commands.
`timescale 1ns / 1ps
module psu_front
  import psu_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic in_valid,
  output logic in_ready,
  input  cmd_t in_cmd,
  output logic q_valid,
  input  logic q_ready,
  output cmd_t q_cmd
);

  localparam int Depth = 2;

  cmd_t slots [Depth];
  logic wp;
  logic rp;
  logic [1:0] count;
  logic keep;
  logic push;
  logic pop;

  // Mode 3 carries nothing; drop it at the door
  assign keep = (in_cmd.mode == ModeLoad) || (in_cmd.mode == ModeFit) ||
                (in_cmd.mode == ModeUpd);
  assign in_ready = (count != 2'd2);
  assign push = in_valid && in_ready && keep;
  assign q_valid = (count != 2'd0);
  assign pop = q_valid && q_ready;
  assign q_cmd = slots[rp];

  // Hold queue pointers and count
  always_ff @(posedge clk) begin
    if (rst) begin
      wp <= 1'b0;
      rp <= 1'b0;
      count <= 2'd0;
    end else begin
      if (push) wp <= ~wp;
      if (pop) rp <= ~rp;
      count <= count + {1'b0, push} - {1'b0, pop};
    end
  end

  // Store queued payload
  always_ff @(posedge clk) begin
    if (push) slots[wp] <= in_cmd;
  end

endmodule

FILE: rtl/psu_back.sv
// Back end: swarm memories, best tracking and the per-dimension update datapath.
`timescale 1ns / 1ps
module psu_back
  import psu_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic q_valid,
  output logic q_ready,
  input  cmd_t q_cmd,
  input  logic [15:0] inertia_weight,
  input  logic [15:0] cognitive_gain,
  input  logic [15:0] social_gain,
  input  logic [DcntW-1:0] dimension_count,
  output logic res_valid,
  input  logic res_ready,
  output res_t res
);

  typedef enum logic [3:0] {
    S_IDLE, S_FCHK, S_COEF, S_FCOPY, S_FEND, S_RD, S_MUL, S_SUM, S_OUT
  } state_t;

  state_t state;
  cmd_t cmd;
  logic [DimW-1:0] dim;
  logic [DimW-1:0] last_dim;
  logic signed [31:0] k1;
  logic signed [31:0] k2;
  logic pimp;
  logic gimp;
  logic copy_wr;
  logic [DimW-1:0] copy_dim;

  // Memories
  logic signed [StateWidth-1:0] pos_mem [MaxParticles*MaxDims];
  logic signed [StateWidth-1:0] vel_mem [MaxParticles*MaxDims];
  logic signed [StateWidth-1:0] pb_mem [MaxParticles*MaxDims];
  logic signed [StateWidth-1:0] gb_row [MaxDims];
  logic signed [ScoreW-1:0] pb_score [MaxParticles];
  logic [MaxParticles-1:0] pb_vld;
  logic signed [ScoreW-1:0] gb_score;

  logic signed [StateWidth-1:0] x_rd;
  logic signed [StateWidth-1:0] v_rd;
  logic signed [StateWidth-1:0] p_rd;
  logic signed [StateWidth-1:0] g_rd;
  logic signed [ScoreW-1:0] pb_rd;
  logic pbv_rd;
  logic signed [47:0] t_w;
  logic signed [47:0] t_1;
  logic signed [47:0] t_2;
  logic signed [StateWidth-1:0] vn;
  logic signed [StateWidth-1:0] xn;
  logic res_full;

  logic [AddrW-1:0] addr;
  logic [AddrW-1:0] load_addr;
  logic signed [ScoreW-1:0] cur_pb;
  logic [12:0] r1s;
  logic [12:0] r2s;
  logic [DcntW-1:0] n_use;
  logic signed [47:0] sum_round;

  assign addr = {cmd.particle, dim};
  assign load_addr = {q_cmd.particle, q_cmd.dim_index};
  assign cur_pb = pbv_rd ? pb_rd : ScoreFloor;
  assign r1s = (cmd.rand_one > RandMax) ? RandMax : cmd.rand_one;
  assign r2s = (cmd.rand_two > RandMax) ? RandMax : cmd.rand_two;
  assign n_use = (dimension_count == '0) ? DcntW'(1) :
                 (dimension_count > DcntW'(MaxDims)) ? DcntW'(MaxDims) : dimension_count;
  assign q_ready = (state == S_IDLE) && !res_full;
  assign res_valid = res_full;
  assign sum_round = t_w + t_1 + t_2 + 48'sd8388608;

  // Sequencer and registered result
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      res_full <= 1'b0;
      pb_vld <= '0;
      gb_score <= ScoreFloor;
      copy_wr <= 1'b0;
    end else begin
      if (res_full && res_ready) res_full <= 1'b0;
      copy_wr <= (state == S_FCOPY);
      copy_dim <= dim;
      case (state)
        S_IDLE: begin
          if (q_valid && !res_full) begin
            cmd <= q_cmd;
            dim <= '0;
            last_dim <= DimW'(n_use - DcntW'(1));
            case (q_cmd.mode)
              ModeFit: state <= S_FCHK;
              ModeUpd: state <= S_COEF;
              default: ;
            endcase
          end
        end
        S_FCHK: begin
          pimp <= cmd.fitness > cur_pb;
          gimp <= (cmd.fitness > cur_pb) && (cmd.fitness > gb_score);
          if (cmd.fitness > cur_pb) begin
            pb_score[cmd.particle] <= cmd.fitness;
            pb_vld[cmd.particle] <= 1'b1;
            if (cmd.fitness > gb_score) gb_score <= cmd.fitness;
            state <= S_FCOPY;
          end else begin
            res <= '{out_dim: '0, out_position: '0, out_velocity: '0,
                     personal_improved: 1'b0, global_improved: 1'b0, last: 1'b1};
            res_full <= 1'b1;
            state <= S_IDLE;
          end
        end
        S_COEF: begin
          k1 <= $signed({3'b0, 29'(cognitive_gain) * 29'(r1s)});
          k2 <= $signed({3'b0, 29'(social_gain) * 29'(r2s)});
          state <= S_RD;
        end
        S_FCOPY: begin
          // Read one position element per cycle; the write follows in the next cycle
          if (dim == last_dim) state <= S_FEND;
          else dim <= dim + DimW'(1);
        end
        S_FEND: begin
          res <= '{out_dim: '0, out_position: '0, out_velocity: '0,
                   personal_improved: pimp, global_improved: gimp, last: 1'b1};
          res_full <= 1'b1;
          state <= S_IDLE;
        end
        S_RD: state <= S_MUL;
        S_MUL: state <= S_SUM;
        S_SUM: state <= S_OUT;
        S_OUT: begin
          if (!res_full) begin
            res <= '{out_dim: dim, out_position: xn, out_velocity: vn,
                     personal_improved: 1'b0, global_improved: 1'b0,
                     last: (dim == last_dim)};
            res_full <= 1'b1;
            if (dim == last_dim) state <= S_IDLE;
            else begin
              dim <= dim + DimW'(1);
              state <= S_RD;
            end
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // Read element rows and the stored score
  always_ff @(posedge clk) begin
    x_rd <= pos_mem[addr];
    v_rd <= vel_mem[addr];
    p_rd <= pb_mem[addr];
    g_rd <= gb_row[dim];
    pb_rd <= pb_score[q_cmd.particle];
    pbv_rd <= pb_vld[q_cmd.particle];
  end

  // Multiply terms, then round and saturate
  always_ff @(posedge clk) begin
    if (state == S_MUL) begin
      t_w <= 48'($signed({1'b0, inertia_weight}) * v_rd) <<< 12;
      t_1 <= 48'(k1 * (48'(p_rd) - 48'(x_rd)));
      t_2 <= 48'(k2 * (48'(g_rd) - 48'(x_rd)));
    end
    if (state == S_SUM) vn <= sat_state(sum_round >>> 24);
  end

  assign xn = sat_state(48'(x_rd) + 48'(vn));

  // Memory writes
  always_ff @(posedge clk) begin
    if (state == S_IDLE && q_valid && !res_full && q_cmd.mode == ModeLoad) begin
      pos_mem[load_addr] <= q_cmd.load_position;
      vel_mem[load_addr] <= q_cmd.load_velocity;
      pb_mem[load_addr] <= q_cmd.load_position;
    end else if (copy_wr) begin
      pb_mem[{cmd.particle, copy_dim}] <= x_rd;
    end else if (state == S_OUT && !res_full) begin
      pos_mem[addr] <= xn;
      vel_mem[addr] <= vn;
    end
  end

  // Global best row, cleared on reset
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < MaxDims; i++) gb_row[i] <= '0;
    end else if (copy_wr && gimp) begin
      gb_row[copy_dim] <= x_rd;
    end
  end

endmodule

FILE: rtl/particle_swarm_update.sv
// Top level of the particle swarm update block.
`timescale 1ns / 1ps
// A load writes the memories and gives no result. A fitness report that does
// not improve gives its result directly; else it first copies the position row
// into the personal best, one element per dimension in use. An update computes
// its coefficients, then walks each dimension in use (read, multiply, round,
// write), one dimension at a time without pipelining; a stalled result holds it.
// A two-entry queue separates intake from the back end.
module particle_swarm_update
  import psu_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic s_tvalid,
  output logic s_tready,
  // mode, particle, dim_index, load_position, load_velocity, fitness,
  // rand_one, rand_two
  input  logic [103:0] s_tdata,
  output logic m_tvalid,
  input  logic m_tready,
  // out_dim, out_position, out_velocity, personal_improved, global_improved
  output logic [39:0] m_tdata,
  output logic m_tlast,
  input  logic cfg_we,
  input  logic [1:0] cfg_index,
  input  logic [15:0] cfg_data
);

  cmd_t in_cmd;
  cmd_t q_cmd;
  logic q_valid;
  logic q_ready;
  res_t res;
  logic [15:0] inertia_weight;
  logic [15:0] cognitive_gain;
  logic [15:0] social_gain;
  logic [DcntW-1:0] dimension_count;

  assign in_cmd.mode = s_tdata[1:0];
  assign in_cmd.particle = s_tdata[7:2];
  assign in_cmd.dim_index = s_tdata[11:8];
  assign in_cmd.load_position = s_tdata[27:12];
  assign in_cmd.load_velocity = s_tdata[43:28];
  assign in_cmd.fitness = s_tdata[75:44];
  assign in_cmd.rand_one = s_tdata[88:76];
  assign in_cmd.rand_two = s_tdata[101:89];

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      inertia_weight <= 16'd4096;
      cognitive_gain <= 16'd4096;
      social_gain <= 16'd4096;
      dimension_count <= DcntW'(16);
    end else if (cfg_we) begin
      case (cfg_index)
        RegInertia: inertia_weight <= cfg_data;
        RegCognitive: cognitive_gain <= cfg_data;
        RegSocial: social_gain <= cfg_data;
        RegDims: dimension_count <= cfg_data[DcntW-1:0];
        default: ;
      endcase
    end
  end

  psu_front u_front (
    .clk(clk), .rst(rst),
    .in_valid(s_tvalid), .in_ready(s_tready), .in_cmd(in_cmd),
    .q_valid(q_valid), .q_ready(q_ready), .q_cmd(q_cmd)
  );

  psu_back u_back (
    .clk(clk), .rst(rst),
    .q_valid(q_valid), .q_ready(q_ready), .q_cmd(q_cmd),
    .inertia_weight(inertia_weight), .cognitive_gain(cognitive_gain),
    .social_gain(social_gain), .dimension_count(dimension_count),
    .res_valid(m_tvalid), .res_ready(m_tready), .res(res)
  );

  assign m_tdata = {2'b0, res.global_improved, res.personal_improved,
                    res.out_velocity, res.out_position, res.out_dim};
  assign m_tlast = res.last;

endmodule

FILE: rtl/psu_checker.sv
// Port-level checks for the particle swarm update block.
`timescale 1ns / 1ps
module psu_checker (
  input logic clk,
  input logic rst,
  input logic m_tvalid,
  input logic m_tready,
  input logic [39:0] m_tdata,
  input logic m_tlast
);

  // Hold a stalled result
  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    else $error("result changed while stalled");

  // Flags only on single-result fitness items
  a_flag: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && (m_tdata[36] || m_tdata[37]) |-> m_tlast)
    else $error("flag on non-final result");

  // Global improvement implies personal improvement
  a_gimp: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tdata[37] |-> m_tdata[36])
    else $error("global without personal improvement");

  // No result out of reset
  a_rst: assert property (@(posedge clk) $past(rst) |-> !m_tvalid)
    else $error("result right after reset");

endmodule

bind particle_swarm_update psu_checker u_psu_checker (
  .clk(clk), .rst(rst),
  .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tlast(m_tlast)
);

FILE: dv/particle_swarm_update_tb.sv
// Self-checking testbench for the particle swarm update block.
`timescale 1ns / 1ps
module particle_swarm_update_tb;
  import psu_pkg::*;

  localparam int CycleLimit = 400000;
  localparam int DrainCycles = 120;

  typedef struct {
    logic [1:0] mode;
    logic [5:0] particle;
    logic [3:0] dim_index;
    logic signed [15:0] load_position;
    logic signed [15:0] load_velocity;
    logic signed [31:0] fitness;
    logic [12:0] rand_one;
    logic [12:0] rand_two;
  } swarm_cmd_t;

  typedef struct {
    logic [3:0] dim;
    logic signed [15:0] position;
    logic signed [15:0] velocity;
    logic personal;
    logic global_best;
    logic last;
  } swarm_result_t;

  logic clk;
  logic rst;
  logic s_tvalid;
  logic s_tready;
  logic [103:0] s_tdata;
  logic m_tvalid;
  logic m_tready;
  logic [39:0] m_tdata;
  logic m_tlast;
  logic cfg_we;
  logic [1:0] cfg_index;
  logic [15:0] cfg_data;

  particle_swarm_update dut (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tlast(m_tlast),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  // Shadow of the swarm state and the registers
  logic signed [15:0] sh_pos [0:1023];
  logic signed [15:0] sh_vel [0:1023];
  logic signed [15:0] sh_pbest [0:1023];
  logic signed [31:0] sh_pscore [0:63];
  logic signed [15:0] sh_gbest [0:15];
  logic signed [31:0] sh_gscore;
  logic [15:0] sh_w, sh_c1, sh_c2;
  logic [4:0] sh_dims;

  swarm_cmd_t cmd_queue [$];
  swarm_result_t result_queue [$];
  logic [15:0] gen_loaded [0:63];
  int errors = 0;
  int n_updates = 0;
  int n_reports = 0;
  int n_results = 0;
  int n_cfg = 0;
  bit quiet = 0;
  int cycles = 0;

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  function automatic logic signed [15:0] clamp16(input longint s);
    if (s > 32767) return 16'sh7fff;
    if (s < -32768) return 16'sh8000;
    return s[15:0];
  endfunction

  // Apply one accepted command to the shadow and queue what it produces
  task automatic predict_swarm(input swarm_cmd_t c);
    int n, base, z;
    longint k1, k2, x, v, sum;
    logic [12:0] r1, r2;
    logic signed [15:0] vn, xn;
    swarm_result_t r;
    n = (sh_dims == 0) ? 1 : (sh_dims > MaxDims) ? MaxDims : sh_dims;
    base = c.particle * MaxDims;
    case (c.mode)
      ModeLoad: begin
        sh_pos[base + c.dim_index] = c.load_position;
        sh_vel[base + c.dim_index] = c.load_velocity;
        sh_pbest[base + c.dim_index] = c.load_position;
      end
      ModeFit: begin
        r = '{default: 0};
        r.last = 1;
        n_reports++;
        if (c.fitness > sh_pscore[c.particle]) begin
          r.personal = 1;
          sh_pscore[c.particle] = c.fitness;
          for (int d = 0; d < n; d++) sh_pbest[base + d] = sh_pos[base + d];
          if (c.fitness > sh_gscore) begin
            r.global_best = 1;
            sh_gscore = c.fitness;
            for (int d = 0; d < n; d++) sh_gbest[d] = sh_pos[base + d];
          end
        end
        result_queue.push_back(r);
      end
      ModeUpd: begin
        n_updates++;
        r1 = (c.rand_one > RandMax) ? RandMax : c.rand_one;
        r2 = (c.rand_two > RandMax) ? RandMax : c.rand_two;
        k1 = longint'(sh_c1) * longint'(r1);
        k2 = longint'(sh_c2) * longint'(r2);
        for (int d = 0; d < n; d++) begin
          z = base + d;
          x = sh_pos[z];
          v = sh_vel[z];
          sum = (longint'(sh_w) * v) * 4096 + k1 * (longint'(sh_pbest[z]) - x)
              + k2 * (longint'(sh_gbest[d]) - x);
          vn = clamp16((sum + (longint'(1) << 23)) >>> 24);
          xn = clamp16(x + longint'(vn));
          sh_vel[z] = vn;
          sh_pos[z] = xn;
          r.dim = 4'(d);
          r.position = xn;
          r.velocity = vn;
          r.personal = 0;
          r.global_best = 0;
          r.last = (d == n - 1);
          result_queue.push_back(r);
        end
      end
      default: ;
    endcase
  endtask

  task automatic report_mismatch(input string what, input longint got, input longint want);
    $display("mismatch at %0t: %s got %0d expected %0d", $realtime, what, got, want);
    errors++;
  endtask

  // Driver: present queued commands, idle in random bursts
  int s_idle;
  swarm_cmd_t s_cur;
  always @(posedge clk) begin
    if (rst) begin
      s_tvalid <= 0;
      s_idle = 0;
    end else begin
      if (s_tvalid && s_tready) predict_swarm(s_cur);
      if (!(s_tvalid && !s_tready)) begin
        if (s_idle > 0) begin
          s_idle--;
          s_tvalid <= 0;
        end else if (cmd_queue.size() > 0) begin
          if (!quiet && $urandom_range(0, 7) == 0) begin
            s_idle = $urandom_range(1, 6) - 1;
            s_tvalid <= 0;
          end else begin
            s_cur = cmd_queue.pop_front();
            s_tvalid <= 1;
            s_tdata <= {2'b00, s_cur.rand_two, s_cur.rand_one, s_cur.fitness,
                        s_cur.load_velocity, s_cur.load_position, s_cur.dim_index,
                        s_cur.particle, s_cur.mode};
          end
        end else begin
          s_tvalid <= 0;
        end
      end
    end
  end

  // Monitor: stall in random bursts, check each result transfer
  int m_idle;
  swarm_result_t m_want;
  always @(posedge clk) begin
    if (rst) begin
      m_tready <= 0;
      m_idle = 0;
    end else begin
      if (m_tvalid && m_tready) begin
        n_results++;
        if (result_queue.size() == 0) begin
          report_mismatch("unexpected result, dim", m_tdata[3:0], -1);
        end else begin
          m_want = result_queue.pop_front();
          if (m_tdata[3:0] !== m_want.dim) report_mismatch("out_dim", m_tdata[3:0], m_want.dim);
          if (m_tdata[19:4] !== m_want.position)
            report_mismatch("out_position", $signed(m_tdata[19:4]), m_want.position);
          if (m_tdata[35:20] !== m_want.velocity)
            report_mismatch("out_velocity", $signed(m_tdata[35:20]), m_want.velocity);
          if (m_tdata[36] !== m_want.personal)
            report_mismatch("personal_improved", m_tdata[36], m_want.personal);
          if (m_tdata[37] !== m_want.global_best)
            report_mismatch("global_improved", m_tdata[37], m_want.global_best);
          if (m_tlast !== m_want.last) report_mismatch("last", m_tlast, m_want.last);
        end
      end
      if (m_idle > 0) begin
        m_idle--;
        m_tready <= 0;
      end else if (!quiet && $urandom_range(0, 7) == 0) begin
        m_idle = $urandom_range(1, 6) - 1;
        m_tready <= 0;
      end else begin
        m_tready <= 1;
      end
    end
  end

  // Watchdog
  always @(posedge clk) begin
    cycles++;
    if (cycles > CycleLimit) begin
      $display("timeout after %0d cycles", cycles);
      $display("FAILURE");
      $finish;
    end
  end

  task automatic push_cmd(input logic [1:0] mode, input int p, input int di,
                          input logic [15:0] lp, input logic [15:0] lv,
                          input logic [31:0] fit, input logic [12:0] r1,
                          input logic [12:0] r2);
    swarm_cmd_t c;
    c.mode = mode; c.particle = 6'(p); c.dim_index = 4'(di);
    c.load_position = lp; c.load_velocity = lv; c.fitness = fit;
    c.rand_one = r1; c.rand_two = r2;
    if (mode == ModeLoad) gen_loaded[p][di] = 1'b1;
    cmd_queue.push_back(c);
  endtask

  // One random command; reports and updates only touch fully loaded particles
  task automatic push_random;
    int ready [$];
    int pick, p;
    logic [12:0] r1, r2;
    logic [31:0] fit;
    for (int i = 0; i < 64; i++) if (gen_loaded[i] == 16'hffff) ready.push_back(i);
    pick = $urandom_range(0, 99);
    r1 = ($urandom_range(0, 5) == 0) ? 13'($urandom) : 13'($urandom_range(0, 4096));
    r2 = ($urandom_range(0, 5) == 0) ? 13'($urandom) : 13'($urandom_range(0, 4096));
    fit = ($urandom_range(0, 3) == 0) ? $urandom : $urandom_range(0, 2000) - 1000;
    if (pick < 4) begin
      push_cmd(2'd3, $urandom_range(0, 63), $urandom_range(0, 15), 16'($urandom),
               16'($urandom), $urandom, 13'($urandom), 13'($urandom));
    end else if (pick < 40 || ready.size() == 0) begin
      p = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 63) : $urandom_range(0, 7);
      push_cmd(ModeLoad, p, $urandom_range(0, 15), 16'($urandom_range(0, 4000) - 2000),
               16'(($urandom_range(0, 7) == 0) ? $urandom : $urandom_range(0, 400) - 200),
               $urandom, 13'($urandom), 13'($urandom));
    end else begin
      p = ready[$urandom_range(0, ready.size() - 1)];
      push_cmd((pick < 65) ? ModeFit : ModeUpd, p, $urandom_range(0, 15), 16'($urandom),
               16'($urandom), fit, r1, r2);
    end
  endtask

  task automatic wait_idle;
    do @(negedge clk);
    while (cmd_queue.size() != 0 || s_tvalid || result_queue.size() != 0);
    repeat (DrainCycles) @(negedge clk);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [15:0] val);
    @(posedge clk);
    cfg_we <= 1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    cfg_we <= 0;
    n_cfg++;
    case (idx)
      RegInertia: sh_w = val;
      RegCognitive: sh_c1 = val;
      RegSocial: sh_c2 = val;
      RegDims: sh_dims = val[4:0];
      default: ;
    endcase
  endtask

  task automatic set_all(input logic [15:0] w, input logic [15:0] c1,
                         input logic [15:0] c2, input logic [4:0] dims);
    write_reg(RegInertia, w);
    write_reg(RegCognitive, c1);
    write_reg(RegSocial, c2);
    write_reg(RegDims, {11'd0, dims});
  endtask

  initial begin
    rst = 1;
    cfg_we = 0;
    cfg_index = '0;
    cfg_data = '0;
    sh_w = 16'd4096; sh_c1 = 16'd4096; sh_c2 = 16'd4096; sh_dims = 5'd16;
    for (int i = 0; i < 1024; i++) begin
      sh_pos[i] = 0; sh_vel[i] = 0; sh_pbest[i] = 0;
    end
    for (int i = 0; i < 64; i++) begin
      sh_pscore[i] = ScoreFloor;
      gen_loaded[i] = '0;
    end
    for (int i = 0; i < 16; i++) sh_gbest[i] = 0;
    sh_gscore = ScoreFloor;
    repeat (2) @(posedge clk);
    rst <= 0;

    // Directed: extreme loads on particle 63, score edges, rand clamp, mode 3
    for (int d = 0; d < 16; d++)
      push_cmd(ModeLoad, 63, d, (d % 2) ? 16'h7fff : 16'h8000,
               (d % 3 == 0) ? 16'h8000 : 16'h7fff, 0, 0, 0);
    push_cmd(ModeFit, 63, 0, 0, 0, 32'h8000_0000, 0, 0);
    push_cmd(ModeUpd, 63, 0, 0, 0, 0, 13'd0, 13'd0);
    push_cmd(ModeFit, 63, 0, 0, 0, 32'h7fff_ffff, 0, 0);
    push_cmd(ModeFit, 63, 0, 0, 0, 32'h7fff_ffff, 0, 0);
    push_cmd(ModeUpd, 63, 0, 0, 0, 0, 13'h1fff, 13'd4096);
    push_cmd(2'd3, 63, 15, 16'hffff, 16'hffff, 32'hffff_ffff, 13'h1fff, 13'h1fff);
    push_cmd(ModeUpd, 63, 0, 0, 0, 0, 13'd4097, 13'd1);
    wait_idle();

    // Random phases under several register settings, extremes among them
    for (int ph = 0; ph < 5; ph++) begin
      case (ph)
        0: set_all(16'd4096, 16'd4096, 16'd4096, 5'd16);
        1: set_all(16'd0, 16'hffff, 16'hffff, 5'd1);
        2: set_all(16'hffff, 16'd0, 16'd0, 5'd0);
        3: set_all(16'd2867, 16'd6144, 16'd6144, 5'd31);
        default: set_all(16'($urandom), 16'($urandom), 16'($urandom),
                         5'($urandom_range(1, 16)));
      endcase
      if (ph == 4) quiet = 1;
      for (int i = 0; i < 88; i++) push_random();
      wait_idle();
    end

    $display("covered %0d updates, %0d fitness reports, %0d results, %0d register writes",
             n_updates, n_reports, n_results, n_cfg);
    $display("with random stalls on both sides and saturating register settings");
    if (errors == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
